### design/zsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package zsg_pkg;
  localparam int VW = 32;
  localparam int ZW = 3;
  localparam int NW = 16;
  localparam int QW = VW + NW;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_ZONES = 3'd1;
  localparam logic [2:0] REG_Z0    = 3'd2;
  localparam logic [2:0] REG_Z1    = 3'd3;
  localparam logic [2:0] REG_HYST  = 3'd4;
  localparam logic [2:0] REG_RAMP  = 3'd5;
  localparam logic [2:0] REG_LOCK  = 3'd6;
  localparam logic [2:0] REG_RATE  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_DIVIDE, ST_FINISH, ST_SHOW
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic div_start;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;
endpackage
`default_nettype wire

### design/zsg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface zsg_in_if import zsg_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [VW-1:0] max_setpoint;
  logic signed [VW-1:0] feedback_value;
  logic signed [VW-1:0] control_value;
  logic signed [VW-1:0] preferred_control;
  logic signed [VW-1:0] external_min_control;
  logic signed [VW-1:0] external_max_control;
  modport source (output valid, max_setpoint, feedback_value, control_value,
                  preferred_control, external_min_control, external_max_control,
                  input ready);
  modport sink (input valid, max_setpoint, feedback_value, control_value,
                preferred_control, external_min_control, external_max_control,
                output ready);
endinterface

interface zsg_out_if import zsg_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [VW-1:0] setpoint;
  logic signed [VW-1:0] max_control_limit;
  logic signed [VW-1:0] min_control_limit;
  logic [ZW-1:0] zone_state;
  modport source (output valid, setpoint, max_control_limit, min_control_limit,
                  zone_state, input ready);
  modport sink (input valid, setpoint, max_control_limit, min_control_limit,
                zone_state, output ready);
endinterface
`default_nettype wire

### design/zsg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module zsg_ctrl import zsg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);
  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: state_next = status.need_div ? ST_DIVIDE : ST_FINISH;
      ST_DIVIDE: if (status.div_done) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_SHOW;
      ST_SHOW:   if (out_ready) state_next = in_valid ? ST_DECIDE : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.div_start = status.need_div;
      end
      ST_FINISH: cmd.finish = 1'b1;
      ST_SHOW: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        cmd.load = out_ready & in_valid;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### design/zsg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module zsg_div import zsg_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [QW-1:0] dividend,
  input  wire logic [NW-1:0] divisor,
  output logic [QW-1:0]      quotient,
  output logic               done
);
  localparam int CW = $clog2(QW + 1);
  logic [QW-1:0] quo;
  logic [NW:0]   rem;
  logic [NW-1:0] dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic [NW:0]   trial;

  // Restoring division, two quotient bits a cycle.
  logic [NW:0] r1, r2;
  logic        q1, q2;
  logic [QW-1:0] quo1;
  always_comb begin
    trial = {rem[NW-1:0], quo[QW-1]};
    q1 = trial >= {1'b0, dvs};
    r1 = q1 ? trial - {1'b0, dvs} : trial;
    quo1 = {quo[QW-2:0], q1};
    trial = {r1[NW-1:0], quo1[QW-1]};
    q2 = trial >= {1'b0, dvs};
    r2 = q2 ? trial - {1'b0, dvs} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(QW / 2);
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (busy) begin
        quo <= {quo1[QW-2:0], q2};
        rem <= r2;
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = quo;
endmodule
`default_nettype wire

### design/zsg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module zsg_datapath import zsg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ctl_cmd_t   cmd,
  output dp_status_t      status,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [63:0] cfg_data,
  zsg_in_if.sink          in_ch,
  zsg_out_if.source       out_ch
);
  localparam int WW = VW + 3;
  typedef logic signed [WW-1:0] w_t;

  logic [1:0]  mode_bits, zones_in_use;
  logic [63:0] zb0, zb1;
  logic [30:0] hyst, rate_lim;
  logic [NW-1:0] ramp_steps, lock_steps;
  logic [ZW-1:0] mstate;
  logic [NW-1:0] ramp_count, lock_count;
  logic          locked;

  logic signed [VW-1:0] ms, fb, cv, uo, emin, emax;
  logic signed [VW-1:0] r_out, mx_out, mn_out;

  // Registers of the second half of a sample.
  logic [ZW-1:0] st_d;
  logic [NW-1:0] rc_d, lc_d;
  logic          lk_d;
  logic          active_d, ramp_d;
  w_t            start_d, span_d, rbase_d;
  logic          spneg_d;
  logic [QW-1:0] q;
  logic          div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits <= 2'd3; zones_in_use <= '0; zb0 <= '0; zb1 <= '0;
      hyst <= '0; ramp_steps <= '0; lock_steps <= '0; rate_lim <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_bits <= cfg_data[1:0];
        REG_ZONES: zones_in_use <= cfg_data[1:0];
        REG_Z0:    zb0 <= cfg_data;
        REG_Z1:    zb1 <= cfg_data;
        REG_HYST:  hyst <= cfg_data[30:0];
        REG_RAMP:  ramp_steps <= cfg_data[NW-1:0];
        REG_LOCK:  lock_steps <= cfg_data[NW-1:0];
        REG_RATE:  rate_lim <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ms <= in_ch.max_setpoint; fb <= in_ch.feedback_value;
      cv <= in_ch.control_value; uo <= in_ch.preferred_control;
      emin <= in_ch.external_min_control; emax <= in_ch.external_max_control;
    end
  end

  function automatic w_t ext(input logic [VW-1:0] v);
    return w_t'(signed'(v));
  endfunction

  w_t lo0, hi0, lo1, hi1, wms, wfb, wcv, wuo, wemin, wemax, whyst, wrate, dn, up;
  logic [1:0] nz;
  logic       neg;
  always_comb begin
    lo0 = ext(zb0[31:0]); hi0 = ext(zb0[63:32]);
    lo1 = ext(zb1[31:0]); hi1 = ext(zb1[63:32]);
    wms = ext(ms); wfb = ext(fb); wcv = ext(cv); wuo = ext(uo);
    wemin = ext(emin); wemax = ext(emax);
    whyst = w_t'({1'b0, hyst}); wrate = w_t'({1'b0, rate_lim});
    neg = mode_bits[0];
    dn = neg ? wuo - wcv : wcv - wuo;
    up = -dn;
    nz = (zones_in_use > 2'd2) ? 2'd2 : zones_in_use;
    if (nz >= 2'd1 && lo0 >= hi0) nz = 2'd0;
    if (nz == 2'd2 && (lo1 >= hi1 || lo1 <= hi0)) nz = 2'd0;
  end

  // First half: state transition and counters.
  logic [ZW-1:0] s;
  logic [NW-1:0] rc, lc;
  logic          lk, z;
  logic [1:0]    sub;
  w_t            zlo, zhi, rstart, rtarget;
  logic          use_ramp;
  always_comb begin
    s = mstate; rc = ramp_count; lc = lock_count; lk = locked;
    z = mstate[2]; sub = mstate[1:0];
    zlo = z ? lo1 : lo0; zhi = z ? hi1 : hi0;
    if (nz >= 2'd1) begin
      unique case (sub)
        2'd0: begin
          if (z && wms < zlo) s = s - 3'd2;
          else if (zlo + zhi < (wfb <<< 1) && wms > zhi) s = s + 3'd2;
          else if (zlo + wms < (wfb <<< 1) && wms > zlo) s = s + 3'd1;
          else if (z && dn > whyst && rc >= ramp_steps && lc == '0) begin
            s = s - 3'd2; lc = lock_steps;
          end
        end
        2'd1: begin
          if (wms > zhi) s = s + 3'd1;
          else if (zlo + wms > (wfb <<< 1) || wms < zlo) s = s - 3'd1;
        end
        2'd2: begin
          if (wms < zhi) s = s - 3'd1;
          else if (zlo + zhi > (wfb <<< 1)) s = s - 3'd2;
          else if (!z && nz == 2'd2 && up > whyst && rc == '0 &&
                   (!lk || lc == '0) && wms > lo1) begin
            s = s + 3'd2; lc = lock_steps; lk = 1'b1;
          end
        end
        default: ;
      endcase
      z = s[2]; sub = s[1:0];
      if (sub == 2'd0 && z) begin
        if (dn > whyst) begin
          if (rc >= ramp_steps && lc != '0) lc = lc - 1'b1;
        end else lc = lock_steps;
        if (rc < ramp_steps) rc = rc + 1'b1;
      end else if (sub == 2'd2 && !z && nz == 2'd2) begin
        if (up > whyst) begin
          if (rc == '0 && lc != '0) lc = lc - 1'b1;
        end else lc = lock_steps;
        if (rc != '0) rc = rc - 1'b1;
      end
    end
    // Ramp from zone 0 upper towards zone 1 lower in either direction.
    rstart = hi0; rtarget = lo1;
    use_ramp = (ramp_steps != '0) &&
               ((sub == 2'd0 && z) || (sub == 2'd2 && !z && nz == 2'd2));
  end

  w_t sp;
  logic [NW-1:0] rci;
  logic [VW:0]   mag;
  always_comb begin
    sp = rtarget - rstart;
    rci = (rc > ramp_steps) ? ramp_steps : rc;
    mag = sp[WW-1] ? (VW+1)'(0) - sp[VW:0] : sp[VW:0];
  end

  logic [QW-1:0] prod;
  logic          mul_go;
  always_ff @(posedge clk) begin
    if (rst) mul_go <= 1'b0;
    else mul_go <= cmd.div_start;
    if (cmd.decide) begin
      st_d <= (nz >= 2'd1) ? s : mstate;
      rc_d <= rc; lc_d <= lc; lk_d <= lk;
      active_d <= nz >= 2'd1;
      ramp_d <= use_ramp;
      start_d <= rstart; spneg_d <= sp[WW-1];
      prod <= QW'(mag) * QW'(rci);
    end
  end

  assign status.need_div = (nz >= 2'd1) && use_ramp;
  assign status.div_done = div_done;

  zsg_div u_div (
    .clk(clk), .rst(rst), .start(mul_go), .dividend(prod),
    .divisor(ramp_steps), .quotient(q), .done(div_done)
  );

  function automatic w_t rclamp(input w_t u, input w_t c, input w_t r);
    w_t t;
    t = u;
    if (r > 0) begin
      if (t < c - r) t = c - r;
      if (t > c + r) t = c + r;
    end
    return t;
  endfunction

  function automatic logic signed [VW-1:0] sat(input w_t v);
    if (v > ext({1'b0, {(VW-1){1'b1}}})) return {1'b0, {(VW-1){1'b1}}};
    if (v < ext({1'b1, {(VW-1){1'b0}}})) return {1'b1, {(VW-1){1'b0}}};
    return v[VW-1:0];
  endfunction

  // Second half: outputs from the new state.
  w_t r, mx, mn, rcu, ramped;
  always_comb begin
    r = wms; mx = wemax; mn = wemin;
    rcu = rclamp(wuo, wcv, wrate);
    ramped = spneg_d ? start_d - w_t'(q) : start_d + w_t'(q);
    rbase_d = '0;
    if (active_d) begin
      unique case (st_d[1:0])
        2'd0: begin
          r = ramp_d ? ramped : (st_d[2] ? lo1 : lo0);
          if (neg) begin
            mx = rcu; if (mx < mn) mx = mn;
          end else begin
            mn = rcu; if (mn > mx) mn = mx;
          end
          if (!st_d[2] && wms < lo0) begin
            r = wms; mx = wemax; mn = wemin;
          end
        end
        2'd1: begin
          r = wms;
          if (neg) begin
            mn = rcu; if (mn > mx) mn = mx;
          end else begin
            mx = rcu; if (mx < mn) mx = mn;
          end
        end
        2'd2: begin
          r = ramp_d ? ramped : (st_d[2] ? hi1 : hi0);
          if (neg) mn = rcu; else mx = rcu;
        end
        default: ;
      endcase
      if (mx > wemax) mx = wemax;
      if (mn < wemin) mn = wemin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= '0; ramp_count <= '0; lock_count <= '0; locked <= 1'b1;
    end else begin
      if (cmd.finish) begin
        mstate <= st_d; ramp_count <= rc_d; lock_count <= lc_d; locked <= lk_d;
      end
      if (cfg_we && cfg_index == REG_MODE) locked <= cfg_data[1];
    end
    if (cmd.finish) begin
      r_out <= sat(r + rbase_d); mx_out <= sat(mx); mn_out <= sat(mn);
    end
  end

  assign out_ch.setpoint = r_out;
  assign out_ch.max_control_limit = mx_out;
  assign out_ch.min_control_limit = mn_out;
  assign out_ch.zone_state = mstate;
endmodule
`default_nettype wire

### design/zoned_setpoint_generator_unit.sv
// Zoned setpoint generator.
// One input item (maximum setpoint, feedback, control action, preferred
// action and external limits) gives one result item: setpoint, maximum and
// minimum control limits and the new zone state. Both channels use
// valid/ready; an item is taken when both are high.
// With no ramp active, a result passes the decide and finish states before it
// can be taken; when the setpoint ramps it also waits on the 48-bit ramp
// division, which retires two quotient bits a cycle.
// A result is held until the receiver takes it; the next item is accepted in
// the same cycle as the result leaves, so a stalled receiver stalls the input.
// Configuration writes go through cfg_we, cfg_index and cfg_data while idle;
// a user rule the block does not enforce. Writing the mode register also
// reloads the transition lock from bit one. Reset restores register
// defaults, clears the zone state and counters and sets the transition lock.
`timescale 1ns / 1ps
`default_nettype none
module zoned_setpoint_generator_unit import zsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  zsg_in_if.sink           in_ch,
  zsg_out_if.source        out_ch
);
  ctl_cmd_t   cmd;
  dp_status_t status;

  zsg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(status), .cmd(cmd)
  );

  zsg_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
`default_nettype wire
